// ===== hdl/centi_log10_approximation_defines.svh =====
// Assertion macros shared by the checker of centi_log10_approximation.
// Depends on nothing; the using module must provide clk and rst_n.
`ifndef CENTI_LOG10_APPROXIMATION_DEFINES_SVH
`define CENTI_LOG10_APPROXIMATION_DEFINES_SVH

// prop holds at every clock edge outside reset
`define CL10_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expr never holds outside reset
`define CL10_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== hdl/cl10_pkg.sv =====
// Shared constants, tables and stage types for the centi-log10 pipeline.
// No dependencies.
package cl10_pkg;

    localparam int VALUE_W      = 32;
    localparam int K_W          = 5;
    localparam int RATIO_W      = 8;
    localparam int CORR_W       = 6;
    localparam int OUT_W        = 10;
    localparam int PROD_W       = VALUE_W + 7;
    localparam int THRESH_COUNT = 17;
    localparam int LATENCY      = 4;

    localparam logic [6:0]        RATIO_SCALE  = 7'd100;
    localparam logic [CORR_W-1:0] CORR_DEFAULT = 6'd32;

    // ratio thresholds; correction is twice the index of the first one >= ratio
    localparam logic [RATIO_W-1:0] THRESH [THRESH_COUNT] = '{
        8'd100, 8'd104, 8'd109, 8'd114, 8'd120, 8'd125, 8'd131, 8'd138, 8'd144,
        8'd151, 8'd158, 8'd166, 8'd173, 8'd182, 8'd190, 8'd199, 8'd208
    };

    // floor(301*k/10) for k = 0..31
    localparam logic [OUT_W-1:0] BASE_TAB [2**K_W] = '{
        10'd0,   10'd30,  10'd60,  10'd90,  10'd120, 10'd150, 10'd180, 10'd210,
        10'd240, 10'd270, 10'd301, 10'd331, 10'd361, 10'd391, 10'd421, 10'd451,
        10'd481, 10'd511, 10'd541, 10'd571, 10'd602, 10'd632, 10'd662, 10'd692,
        10'd722, 10'd752, 10'd782, 10'd812, 10'd842, 10'd872, 10'd903, 10'd933
    };

    typedef struct packed {
        logic [VALUE_W-1:0] v;
        logic [K_W-1:0]     k;
    } lod_t;

    typedef struct packed {
        logic [VALUE_W-1:0] m;
        logic [K_W-1:0]     k;
    } norm_t;

    typedef struct packed {
        logic [RATIO_W-1:0] ratio;
        logic [OUT_W-1:0]   base;
    } scale_t;

endpackage

// ===== hdl/centi_log10_approximation.sv =====
// Top level of the centi-log10 pipeline; depends on cl10_pkg and the four stage modules.
// Result path: each item passes the stage registers in order, and done is the valid bit of
// the correction stage register.
// Throughput: one item per cycle; four register stages (leading-one detect,
// normalize shift, x100 multiply, threshold correction). busy stays low.
// Reset: rst_n asynchronous, active low, clears the stage valid bits; in-flight items drop.
module centi_log10_approximation (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [cl10_pkg::VALUE_W-1:0] value,
    output logic                         done,
    output logic [cl10_pkg::OUT_W-1:0]   centi_log
);

    logic             lod_valid;
    cl10_pkg::lod_t   lod_data;
    logic             norm_valid;
    cl10_pkg::norm_t  norm_data;
    logic             scale_valid;
    cl10_pkg::scale_t scale_data;

    assign busy = 1'b0;

    cl10_lod u_lod (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .value     (value),
        .out_valid (lod_valid),
        .out_data  (lod_data)
    );

    cl10_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (lod_valid),
        .in_data   (lod_data),
        .out_valid (norm_valid),
        .out_data  (norm_data)
    );

    cl10_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (norm_valid),
        .in_data   (norm_data),
        .out_valid (scale_valid),
        .out_data  (scale_data)
    );

    cl10_corr u_corr (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (scale_valid),
        .in_data   (scale_data),
        .done      (done),
        .centi_log (centi_log)
    );

endmodule

// ===== hdl/cl10_lod.sv =====
// Stage 1: leading-one position of the input item.
// Depends on cl10_pkg.
module cl10_lod (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [cl10_pkg::VALUE_W-1:0] value,
    output logic                         out_valid,
    output cl10_pkg::lod_t               out_data
);

    logic           valid_reg;
    cl10_pkg::lod_t data_reg;
    cl10_pkg::lod_t data_next;

    // zero input leaves k at 0
    always_comb
    begin
        data_next.v = value;
        data_next.k = '0;
        for (int i = 0; i < cl10_pkg::VALUE_W; i++)
        begin
            if (value[i])
            begin
                data_next.k = cl10_pkg::K_W'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== hdl/cl10_norm.sv =====
// Stage 2: shifts the leading one to the top bit.
// Depends on cl10_pkg.
module cl10_norm (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  cl10_pkg::lod_t  in_data,
    output logic            out_valid,
    output cl10_pkg::norm_t out_data
);

    logic                      valid_reg;
    cl10_pkg::norm_t           data_reg;
    cl10_pkg::norm_t           data_next;
    logic [cl10_pkg::K_W-1:0]  shamt;

    always_comb
    begin
        shamt       = cl10_pkg::K_W'(cl10_pkg::VALUE_W - 1) - in_data.k;
        data_next.m = in_data.v << shamt;
        data_next.k = in_data.k;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== hdl/cl10_scale.sv =====
// Stage 3: mantissa ratio floor(value*100/2^k) and the integer-part base.
// Depends on cl10_pkg.
module cl10_scale (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  cl10_pkg::norm_t  in_data,
    output logic             out_valid,
    output cl10_pkg::scale_t out_data
);

    logic                        valid_reg;
    cl10_pkg::scale_t            data_reg;
    cl10_pkg::scale_t            data_next;
    logic [cl10_pkg::PROD_W-1:0] prod;

    // m = value << (31-k), so m*100 >> 31 is the exact ratio; zero gives zero
    always_comb
    begin
        prod = cl10_pkg::PROD_W'(in_data.m) * cl10_pkg::PROD_W'(cl10_pkg::RATIO_SCALE);
        data_next.ratio = prod[cl10_pkg::PROD_W-1 -: cl10_pkg::RATIO_W];
        data_next.base  = cl10_pkg::BASE_TAB[in_data.k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== hdl/cl10_corr.sv =====
// Stage 4: threshold correction, final sum and result register.
// Depends on cl10_pkg.
module cl10_corr (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  cl10_pkg::scale_t           in_data,
    output logic                       done,
    output logic [cl10_pkg::OUT_W-1:0] centi_log
);

    logic                        done_reg;
    logic [cl10_pkg::OUT_W-1:0]  result_reg;
    logic [cl10_pkg::OUT_W-1:0]  result_next;
    logic [cl10_pkg::CORR_W-1:0] corr;

    // first qualifying threshold wins: scan from the top down
    always_comb
    begin
        corr = cl10_pkg::CORR_DEFAULT;
        for (int i = cl10_pkg::THRESH_COUNT - 1; i >= 0; i--)
        begin
            if (in_data.ratio <= cl10_pkg::THRESH[i])
            begin
                corr = cl10_pkg::CORR_W'(2 * i);
            end
        end
        result_next = in_data.base + cl10_pkg::OUT_W'(corr);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done      = done_reg;
    assign centi_log = result_reg;

endmodule

// ===== hdl/cl10_checker.sv =====
// Port-level checks for centi_log10_approximation, attached by bind.
// Depends on cl10_pkg and centi_log10_approximation_defines.svh.
`include "centi_log10_approximation_defines.svh"

module cl10_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic [cl10_pkg::VALUE_W-1:0] value,
    input logic                         done,
    input logic [cl10_pkg::OUT_W-1:0]   centi_log
);

    logic accept;
    logic zero_acc;
    logic top_acc;
    logic zero_out;
    logic top_out;

    assign accept   = start && !busy;
    assign zero_acc = accept && (value == '0);
    assign top_acc  = accept && value[cl10_pkg::VALUE_W-1];
    assign zero_out = (centi_log == '0);
    // k = 31 gives base 933; correction adds at most 32
    assign top_out  = (centi_log >= 10'd933) && (centi_log <= 10'd965);

    // every accepted item yields exactly one result, a fixed latency later
    `CL10_ASSERT(a_item_done, accept |-> ##(cl10_pkg::LATENCY) done, "item lost")
    `CL10_ASSERT(a_done_src, done |-> $past(accept, cl10_pkg::LATENCY), "spurious result")
    `CL10_ASSERT(a_zero_in, zero_acc |-> ##(cl10_pkg::LATENCY) zero_out, "zero input not zero")
    `CL10_ASSERT(a_top_bit, top_acc |-> ##(cl10_pkg::LATENCY) top_out, "top range wrong")

endmodule

bind centi_log10_approximation cl10_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .value     (value),
    .done      (done),
    .centi_log (centi_log)
);

// ===== sim/centi_log10_approximation_tb.sv =====
// Self-checking testbench for centi_log10_approximation: drives 32-bit values,
// predicts the approximate 100*log10 of each and checks every done strobe.
// Depends on cl10_pkg and the centi_log10_approximation RTL.
`timescale 1ns / 100ps

module centi_log10_approximation_tb;

    localparam int          RESET_CYCLES  = 4;
    localparam int          DRAIN_CYCLES  = 12;
    localparam int          CYCLE_LIMIT   = 200000;
    localparam int          RANDOM_ITEMS  = 1330;
    localparam int unsigned RATIO_BOUNDS [17] = '{
        100, 104, 109, 114, 120, 125, 131, 138, 144,
        151, 158, 166, 173, 182, 190, 199, 208
    };

    // Holds the predicted log of every accepted value until its strobe arrives.
    class centi_log_scoreboard;
        logic [cl10_pkg::OUT_W-1:0] pending_logs [$];
        int                         errors;

        function new();
            errors = 0;
        endfunction

        function automatic logic [cl10_pkg::OUT_W-1:0] centi_log_of(
            logic [cl10_pkg::VALUE_W-1:0] v);
            int unsigned msb;
            int unsigned corr;
            logic [39:0] scaled;
            logic [39:0] ratio;
            int unsigned sum;
            msb = 0;
            if (v == '0)
            begin
                return '0;
            end
            for (int b = 0; b < 32; b++)
            begin
                if (v[b])
                begin
                    msb = b;
                end
            end
            scaled = 40'(v) * 40'd100;
            ratio  = scaled >> msb;
            corr   = 32;
            for (int i = 16; i >= 0; i--)
            begin
                if (ratio <= 40'(RATIO_BOUNDS[i]))
                begin
                    corr = 2 * i;
                end
            end
            sum = (301 * msb) / 10 + corr;
            return sum[cl10_pkg::OUT_W-1:0];
        endfunction

        function void note_value(logic [cl10_pkg::VALUE_W-1:0] v);
            pending_logs.push_back(centi_log_of(v));
        endfunction

        function void check_log(logic [cl10_pkg::OUT_W-1:0] actual);
            logic [cl10_pkg::OUT_W-1:0] wanted;
            if (pending_logs.size() == 0)
            begin
                errors++;
                $error("centi_log: expected none, got %0d", actual);
                return;
            end
            wanted = pending_logs.pop_front();
            if (actual !== wanted)
            begin
                errors++;
                $error("centi_log: expected %0d, got %0d", wanted, actual);
            end
        endfunction

        function int pending();
            return pending_logs.size();
        endfunction
    endclass

    logic                         clk       = 1'b0;
    logic                         rst_n     = 1'b0;
    logic                         start     = 1'b0;
    logic [cl10_pkg::VALUE_W-1:0] value     = '0;
    logic                         busy;
    logic                         done;
    logic [cl10_pkg::OUT_W-1:0]   centi_log;

    centi_log_scoreboard log_board = new();
    int                  cycle_count = 0;
    bit                  gaps_on     = 1'b1;

    centi_log10_approximation DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .value     (value),
        .done      (done),
        .centi_log (centi_log)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // accepted items and result strobes, sampled at the edge that takes them
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            log_board.note_value(value);
        end
        if (rst_n && done)
        begin
            log_board.check_log(centi_log);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic idle_for(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic send_value(logic [cl10_pkg::VALUE_W-1:0] v);
        if (gaps_on && $urandom_range(0, 99) < 27)
        begin
            idle_for($urandom_range(1, 3));
        end
        start <= 1'b1;
        value <= v;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
    endtask

    task automatic wait_all_results();
        start <= 1'b0;
        @(posedge clk);
        while (log_board.pending() > 0)
        begin
            @(posedge clk);
        end
    endtask

    // smallest value with leading one at msb whose ratio lands on bound
    function automatic logic [cl10_pkg::VALUE_W-1:0] at_ratio(int unsigned bound,
                                                             int unsigned msb);
        logic [63:0] wide;
        wide = ((64'(bound) << msb) + 64'd99) / 64'd100;
        return wide[cl10_pkg::VALUE_W-1:0];
    endfunction

    function automatic logic [cl10_pkg::VALUE_W-1:0] random_value();
        int unsigned msb;
        logic [cl10_pkg::VALUE_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2:
            begin
                v = $urandom;
            end
            3, 4, 5:
            begin
                msb = $urandom_range(0, 31);
                v   = ($urandom | 32'h8000_0000) >> (31 - msb);
            end
            6, 7:
            begin
                v = at_ratio(RATIO_BOUNDS[$urandom_range(0, 15)], $urandom_range(7, 31))
                    - $urandom_range(0, 1);
            end
            8:
            begin
                v = $urandom_range(0, 300);
            end
            default:
            begin
                v = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF - $urandom_range(0, 50)
                                                 : '0;
            end
        endcase
        return v;
    endfunction

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes, top bit set, and every correction step at its exact boundary
        send_value('0);
        send_value(32'd1);
        send_value(32'd2);
        send_value(32'd3);
        send_value(32'h7FFF_FFFF);
        send_value(32'h8000_0000);
        send_value(32'hFFFF_FFFF);
        send_value(32'hAAAA_AAAA);
        send_value(32'h5555_5555);
        for (int i = 0; i < 16; i++)
        begin
            send_value(at_ratio(RATIO_BOUNDS[i], 7 + (i * 3) % 25));
        end
        wait_all_results();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            gaps_on = !(n >= 400 && n < 700);
            if (n == 900)
            begin
                wait_all_results();
            end
            send_value(random_value());
        end

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (log_board.pending() == 0 && log_board.errors == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== centi_log10_approximation.f =====
+incdir+hdl
hdl/cl10_pkg.sv
hdl/cl10_lod.sv
hdl/cl10_norm.sv
hdl/cl10_scale.sv
hdl/cl10_corr.sv
hdl/centi_log10_approximation.sv
hdl/cl10_checker.sv
sim/centi_log10_approximation_tb.sv
